// File: rtl/otr_pkg.sv
`default_nettype none

package otr_pkg;

    localparam int CHANNELS_DEF = 5;

    localparam int CH_W      = 3;
    localparam int MAG_W     = 32;
    localparam int LEVEL_W   = 16;
    localparam int DELAY_W   = 15;
    localparam int COUNT_W   = 16;
    localparam int SQ_W      = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = ((CH_W + MAG_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 + SQ_W + 7) / 8) * 8;

    localparam logic               ENABLE_RST  = 1'b1;
    localparam logic [LEVEL_W-1:0] TRIP_RST    = 16'd100;
    localparam logic [DELAY_W-1:0] DELAY_RST   = 15'd0;
    localparam logic [LEVEL_W-1:0] NOMINAL_RST = 16'd630;

    // Cycles the derived levels need after a register write or reset.
    localparam int SETTLE_W = 2;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

    // The margin round(N * 0.15) equals floor((3N + 10) / 20), taken as
    // ((3N + 10) >> 2) / 5 with a reciprocal multiply that is exact below 2**16.
    localparam logic [15:0] RECIP5     = 16'd52429;
    localparam int          RECIP5_SH  = 18;
    localparam int          MARGIN_W   = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE  = 2'd0,
        REG_TRIP    = 2'd1,
        REG_DELAY   = 2'd2,
        REG_NOMINAL = 2'd3
    } otr_reg_t;

    typedef struct packed {
        logic [SQ_W-1:0] trip_sq;
        logic [SQ_W-1:0] drop_sq;
    } otr_levels_t;

endpackage

`default_nettype wire

// File: rtl/overcurrent_trip_relay.sv
`default_nettype none

// Definite-time phase overcurrent relay for CHANNELS channels sharing one set
// of settings. Each item carries a channel number and a squared magnitude and
// yields one result with the instantaneous and delayed trip bits and the
// squared trip level in use. The block takes one item per cycle unless the
// output stalls or the levels settle; an item is held in an input register
// and its result in an output register. After reset and every register write,
// s_tready stays low while the squared trip and drop levels are recomputed in
// a three-stage pipeline of multipliers; each write also reloads every channel's delay counter.
module overcurrent_trip_relay #(
    parameter int CHANNELS = otr_pkg::CHANNELS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // [2:0] channel, [34:3] magnitude_sq
    input  wire logic [otr_pkg::S_TDATA_W-1:0]   s_tdata,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // [0] instant_trip, [1] delayed_trip, [33:2] trip_level_sq
    output      logic [otr_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic                            cfg_wr_en,
    input  wire logic [otr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [otr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import otr_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EXT_W = (IDX_W > CH_W) ? IDX_W + 1 : CH_W + 1;

    logic                  enable_reg;
    logic [LEVEL_W-1:0]    trip_reg;
    logic [DELAY_W-1:0]    delay_reg;
    logic [LEVEL_W-1:0]    nominal_reg;
    logic [SETTLE_W-1:0]   settle_reg;

    otr_levels_t           levels;

    logic                  in_valid_reg;
    logic [CH_W-1:0]       in_ch_reg;
    logic [MAG_W-1:0]      in_mag_reg;

    logic                  out_valid_reg;
    logic                  out_inst_reg;
    logic                  out_delayed_reg;
    logic [SQ_W-1:0]       out_sq_reg;

    logic                  fault_reg   [CHANNELS];
    logic [COUNT_W-1:0]    count_reg   [CHANNELS];
    logic [1:0]            status_reg  [CHANNELS];

    logic                  advance;
    logic [EXT_W-1:0]      ch_ext;
    logic                  in_range;
    logic [IDX_W-1:0]      sel;
    logic                  fault_old;
    logic [COUNT_W-1:0]    count_old;
    logic [1:0]            status_old;
    logic                  fault_next;
    logic [COUNT_W-1:0]    count_next;
    logic [COUNT_W-1:0]    count_dec;
    logic [1:0]            status_next;
    logic [COUNT_W-1:0]    reload_value;

    otr_levels u_levels (
        .aclk            (aclk),
        .trip_level      (trip_reg),
        .nominal_current (nominal_reg),
        .levels          (levels)
    );

    assign reload_value = {{(COUNT_W-DELAY_W){1'b0}}, delay_reg} + 1'b1;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = (settle_reg == '0) && (!in_valid_reg || advance);

    always_comb begin
        ch_ext     = {{(EXT_W-CH_W){1'b0}}, in_ch_reg};
        in_range   = ch_ext < EXT_W'(CHANNELS);
        sel        = in_range ? ch_ext[IDX_W-1:0] : '0;
        fault_old  = fault_reg[sel];
        count_old  = count_reg[sel];
        status_old = status_reg[sel];

        if (in_mag_reg > levels.trip_sq) begin
            fault_next = 1'b1;
        end else if (in_mag_reg < levels.drop_sq) begin
            fault_next = 1'b0;
        end else begin
            fault_next = fault_old;
        end

        count_dec = (count_old != '0) ? count_old - 1'b1 : count_old;

        if (!enable_reg) begin
            status_next = 2'b00;
            count_next  = count_old;
        end else if (fault_next) begin
            status_next = {status_old[1] | (count_dec == '0), 1'b1};
            count_next  = count_dec;
        end else begin
            status_next = 2'b00;
            count_next  = reload_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= ENABLE_RST;
            trip_reg    <= TRIP_RST;
            delay_reg   <= DELAY_RST;
            nominal_reg <= NOMINAL_RST;
            settle_reg  <= SETTLE_CYCLES;
        end else if (cfg_wr_en) begin
            case (otr_reg_t'(cfg_index))
                REG_ENABLE:  enable_reg  <= cfg_wdata[0];
                REG_TRIP:    trip_reg    <= cfg_wdata[LEVEL_W-1:0];
                REG_DELAY:   delay_reg   <= cfg_wdata[DELAY_W-1:0];
                REG_NOMINAL: nominal_reg <= cfg_wdata[LEVEL_W-1:0];
                default:     enable_reg  <= enable_reg;
            endcase
            settle_reg <= SETTLE_CYCLES;
        end else if (settle_reg != '0) begin
            settle_reg <= settle_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                fault_reg[i]  <= 1'b0;
                status_reg[i] <= 2'b00;
            end
        end else if (advance && in_range) begin
            fault_reg[sel]  <= fault_next;
            status_reg[sel] <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (settle_reg != '0) begin
            for (int i = 0; i < CHANNELS; i++) begin
                count_reg[i] <= reload_value;
            end
        end else if (advance && in_range) begin
            count_reg[sel] <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg  <= s_tdata[CH_W-1:0];
            in_mag_reg <= s_tdata[CH_W +: MAG_W];
        end
        if (advance) begin
            out_inst_reg    <= in_range & status_next[0];
            out_delayed_reg <= in_range & status_next[1];
            out_sq_reg      <= levels.trip_sq;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-2-SQ_W){1'b0}}, out_sq_reg, out_delayed_reg, out_inst_reg};

endmodule

`default_nettype wire

// File: rtl/otr_levels.sv
`default_nettype none

module otr_levels (
    input  wire logic                          aclk,
    input  wire logic [otr_pkg::LEVEL_W-1:0]   trip_level,
    input  wire logic [otr_pkg::LEVEL_W-1:0]   nominal_current,
    output otr_pkg::otr_levels_t               levels
);
    import otr_pkg::*;

    logic [17:0]           scaled_n;
    logic [15:0]           quarter;
    logic [31:0]           recip_prod;
    logic [SQ_W-1:0]       trip_sq_s1_reg;
    logic [MARGIN_W-1:0]   margin_s1_reg;
    logic [LEVEL_W-1:0]    diff;
    logic                  diff_pos;
    logic [SQ_W-1:0]       trip_sq_s2_reg;
    logic [SQ_W-1:0]       seven_s2_reg;
    logic [SQ_W-1:0]       alt_s2_reg;
    otr_levels_t           levels_reg;

    always_comb begin
        scaled_n   = {2'b00, nominal_current} + {1'b0, nominal_current, 1'b0} + 18'd10;
        quarter    = scaled_n[17:2];
        recip_prod = quarter * RECIP5;
        diff_pos   = trip_level > {{(LEVEL_W-MARGIN_W){1'b0}}, margin_s1_reg};
        diff       = trip_level - {{(LEVEL_W-MARGIN_W){1'b0}}, margin_s1_reg};
    end

    always_ff @(posedge aclk) begin
        trip_sq_s1_reg <= trip_level * trip_level;
        margin_s1_reg  <= recip_prod[RECIP5_SH +: MARGIN_W];

        trip_sq_s2_reg <= trip_sq_s1_reg;
        seven_s2_reg   <= trip_sq_s1_reg - (trip_sq_s1_reg >> 3);
        alt_s2_reg     <= diff_pos ? diff * diff : '0;

        levels_reg.trip_sq <= trip_sq_s2_reg;
        levels_reg.drop_sq <= (seven_s2_reg < alt_s2_reg) ? seven_s2_reg : alt_s2_reg;
    end

    assign levels = levels_reg;

endmodule

`default_nettype wire
